// ===== src/esu_pkg.sv =====
// Shared types and constants for the escape sequence unescaper.
package esu_pkg;

    // Most result beats that one input beat can cause.
    localparam int MAX_RES = 3;

    // Default depth of the result queue; a power of two, at least four.
    localparam int FIFO_DEPTH_DEF = 8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       run_last;
        logic       string_end;
    } res_beat_t;

    // Results of one decoded beat, handed from the decoder to the queue.
    typedef struct packed {
        logic [1:0]                 cnt;
        res_beat_t [MAX_RES-1:0]    beat;
    } push_t;

endpackage

// ===== src/esu_decode.sv =====
// Decoder state machine: turns one raw byte into up to three result beats.
module esu_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  esu_pkg::in_beat_t item,
    output esu_pkg::push_t   push
);
    import esu_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_MPEND,
        PH_AFTERM,
        PH_SKIPSP,
        PH_NORMAL,
        PH_BSL,
        PH_CARET,
        PH_OCTAL
    } phase_t;

    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_BEL   = 8'd7;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;

    phase_t     phase_reg, phase_next;
    logic [7:0] oct_val_reg, oct_val_next;
    logic [1:0] oct_cnt_reg, oct_cnt_next;
    logic [7:0] trailer_reg, trailer_next;
    logic [7:0] prev_reg, prev_next;
    logic [1:0] out_cnt_reg, out_cnt_next;
    logic       lesc_reg, lesc_next;

    logic [7:0] ch;
    logic       last;
    logic       ch_oct;
    logic       ch_space;
    logic       plain_en;
    phase_t     plain_phase;
    logic [7:0] caret_up;
    logic [7:0] caret_val;
    logic [7:0] esc_val;
    logic [7:0] oct_acc;

    phase_t     ph_v;
    logic [7:0] ov_v;
    logic [1:0] oc_v;
    logic       a_en;
    logic [7:0] a_byte;
    logic       b_en;
    logic       f_en;
    logic [7:0] f_byte;
    logic       set_cr;
    logic       slot_en   [0:MAX_RES-1];
    logic [7:0] slot_byte [0:MAX_RES-1];
    logic [1:0] cnt_v;
    logic [7:0] prev_v;
    logic       lesc_v;
    logic [7:0] trail_v;
    logic       d_en;
    logic [7:0] list_v [0:3];
    logic [1:0] n_v;
    logic       empty_end;

    assign ch       = item.in_byte;
    assign last     = item.in_last;
    assign ch_oct   = (ch >= CH_0) && (ch <= CH_7);
    assign ch_space = (ch == CH_SPACE) || ((ch >= 8'd9) && (ch <= 8'd13));
    assign plain_en = (ch != CH_BSL) && (ch != CH_CARET);
    assign plain_phase = (ch == CH_BSL)   ? PH_BSL   :
                         (ch == CH_CARET) ? PH_CARET : PH_NORMAL;
    assign caret_up  = ((ch >= CH_LA) && (ch <= CH_LZ)) ? ch - 8'd32 : ch;
    assign caret_val = (ch == CH_QMARK) ? CH_DEL : caret_up - CH_AT;
    // Shifting in an octal digit keeps the low eight bits only.
    assign oct_acc   = {oct_val_reg[4:0], ch[2:0]};

    always_comb
    begin
        case (ch)
            CH_LA:   esc_val = 8'd7;
            CH_LB:   esc_val = 8'd8;
            CH_UE:   esc_val = CH_ESC;
            CH_LE:   esc_val = CH_ESC;
            CH_LN:   esc_val = 8'd10;
            CH_LR:   esc_val = 8'd13;
            CH_LT:   esc_val = 8'd9;
            default: esc_val = ch;
        endcase
    end

    // Phase handling: at most one byte from the phase itself and one plain byte.
    always_comb
    begin
        ph_v   = phase_reg;
        ov_v   = oct_val_reg;
        oc_v   = oct_cnt_reg;
        a_en   = 1'b0;
        a_byte = 8'd0;
        b_en   = 1'b0;
        set_cr = 1'b0;
        case (phase_reg)
            PH_START:
            begin
                if (ch == CH_M)
                begin
                    ph_v = PH_MPEND;
                end
                else
                begin
                    b_en = plain_en;
                    ph_v = plain_phase;
                end
            end
            PH_MPEND:
            begin
                a_en = 1'b1;
                if (ch == CH_DASH)
                begin
                    a_byte = CH_ESC;
                    ph_v   = PH_AFTERM;
                end
                else
                begin
                    a_byte = CH_M;
                    b_en   = plain_en;
                    ph_v   = plain_phase;
                end
            end
            PH_AFTERM:
            begin
                if ((ch == CH_LX) || (ch == CH_UX))
                begin
                    a_en   = 1'b1;
                    a_byte = CH_LX;
                    set_cr = 1'b1;
                    ph_v   = PH_SKIPSP;
                end
                else
                begin
                    b_en = plain_en;
                    ph_v = plain_phase;
                end
            end
            PH_SKIPSP:
            begin
                if (!ch_space)
                begin
                    b_en = plain_en;
                    ph_v = plain_phase;
                end
            end
            PH_BSL:
            begin
                if (ch_oct)
                begin
                    ov_v = {5'd0, ch[2:0]};
                    oc_v = 2'd1;
                    ph_v = PH_OCTAL;
                end
                else
                begin
                    a_en   = 1'b1;
                    a_byte = esc_val;
                    ph_v   = PH_NORMAL;
                end
            end
            PH_CARET:
            begin
                a_en   = 1'b1;
                a_byte = caret_val;
                ph_v   = PH_NORMAL;
            end
            PH_OCTAL:
            begin
                if (ch_oct && (oct_cnt_reg != 2'd3))
                begin
                    if (oct_cnt_reg == 2'd2)
                    begin
                        // The third digit completes the value at once.
                        a_en   = 1'b1;
                        a_byte = oct_acc;
                        ov_v   = 8'd0;
                        oc_v   = 2'd0;
                        ph_v   = PH_NORMAL;
                    end
                    else
                    begin
                        ov_v = oct_acc;
                        oc_v = oct_cnt_reg + 2'd1;
                    end
                end
                else
                begin
                    a_en   = 1'b1;
                    a_byte = oct_val_reg;
                    ov_v   = 8'd0;
                    oc_v   = 2'd0;
                    b_en   = plain_en;
                    ph_v   = plain_phase;
                end
            end
            PH_NORMAL:
            begin
                b_en = plain_en;
                ph_v = plain_phase;
            end
            default:
            begin
                b_en = plain_en;
                ph_v = plain_phase;
            end
        endcase
    end

    // A lone M or pending octal digits are flushed at the end of the string.
    assign f_en   = last && ((ph_v == PH_MPEND) || (ph_v == PH_OCTAL));
    assign f_byte = (ph_v == PH_MPEND) ? CH_M : ov_v;

    always_comb
    begin
        slot_en[0]   = a_en;
        slot_byte[0] = a_byte;
        slot_en[1]   = b_en;
        slot_byte[1] = ch;
        slot_en[2]   = f_en;
        slot_byte[2] = f_byte;
    end

    // Walk the emitted bytes in order, tracking what the trailer rules need.
    always_comb
    begin
        cnt_v   = out_cnt_reg;
        prev_v  = prev_reg;
        lesc_v  = lesc_reg;
        trail_v = set_cr ? CH_CR : trailer_reg;
        n_v     = 2'd0;
        for (int k = 0; k < 4; k++)
        begin
            list_v[k] = 8'd0;
        end
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (slot_en[i])
            begin
                if ((cnt_v == 2'd0) && (slot_byte[i] == CH_ESC))
                begin
                    lesc_v = 1'b1;
                end
                if ((cnt_v == 2'd1) && lesc_v && (slot_byte[i] == CH_RBRK))
                begin
                    trail_v = CH_BEL;
                end
                if (cnt_v != 2'd2)
                begin
                    cnt_v = cnt_v + 2'd1;
                end
                prev_v      = slot_byte[i];
                list_v[n_v] = slot_byte[i];
                n_v         = n_v + 2'd1;
            end
        end
        d_en = last && (trail_v != 8'd0) && ((cnt_v == 2'd0) || (prev_v != trail_v));
        if (d_en)
        begin
            list_v[n_v] = trail_v;
            n_v         = n_v + 2'd1;
        end
    end

    assign empty_end = last && (n_v == 2'd0);

    always_comb
    begin
        push.cnt = 2'd0;
        if (take)
        begin
            push.cnt = empty_end ? 2'd1 : n_v;
        end
        for (int j = 0; j < MAX_RES; j++)
        begin
            push.beat[j].out_byte   = list_v[j];
            push.beat[j].out_valid  = 2'(j) < n_v;
            push.beat[j].run_last   = empty_end ? (j == 0) : (2'(j) == n_v - 2'd1);
            push.beat[j].string_end = last &&
                                      (empty_end ? (j == 0) : (2'(j) == n_v - 2'd1));
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        oct_val_next = oct_val_reg;
        oct_cnt_next = oct_cnt_reg;
        trailer_next = trailer_reg;
        prev_next    = prev_reg;
        out_cnt_next = out_cnt_reg;
        lesc_next    = lesc_reg;
        if (take)
        begin
            if (last)
            begin
                phase_next   = PH_START;
                oct_val_next = 8'd0;
                oct_cnt_next = 2'd0;
                trailer_next = 8'd0;
                prev_next    = 8'd0;
                out_cnt_next = 2'd0;
                lesc_next    = 1'b0;
            end
            else
            begin
                phase_next   = ph_v;
                oct_val_next = ov_v;
                oct_cnt_next = oc_v;
                trailer_next = trail_v;
                prev_next    = prev_v;
                out_cnt_next = cnt_v;
                lesc_next    = lesc_v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            oct_val_reg <= 8'd0;
            oct_cnt_reg <= 2'd0;
            trailer_reg <= 8'd0;
            prev_reg    <= 8'd0;
            out_cnt_reg <= 2'd0;
            lesc_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            oct_val_reg <= oct_val_next;
            oct_cnt_reg <= oct_cnt_next;
            trailer_reg <= trailer_next;
            prev_reg    <= prev_next;
            out_cnt_reg <= out_cnt_next;
            lesc_reg    <= lesc_next;
        end
    end

    // The end of a string always returns the decoder to its start state.
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.in_last |=> phase_reg == PH_START && out_cnt_reg == 2'd0 &&
                                 trailer_reg == 8'd0 && !lesc_reg)
        else $error("decoder state not cleared after string end");

    // A string end always produces at least one result beat.
    a_end_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.in_last |-> push.cnt != 2'd0)
        else $error("string end produced no result beat");

endmodule

// ===== src/esu_out_fifo.sv =====
// Result queue: takes up to three beats a cycle and hands out one while res_ready is high.
module esu_out_fifo #(
    parameter int DEPTH = esu_pkg::FIFO_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  esu_pkg::push_t     push,
    output logic               room,
    output logic               res_valid,
    input  logic               res_ready,
    output esu_pkg::res_beat_t res_beat
);
    import esu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    res_beat_t         mem_reg [0:DEPTH-1];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pop;

    assign room      = cnt_reg <= CW'(DEPTH - MAX_RES);
    assign res_valid = cnt_reg != '0;
    assign res_beat  = mem_reg[rd_ptr_reg];
    assign pop       = res_valid && res_ready;

    assign wr_ptr_next = wr_ptr_reg + AW'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign cnt_next    = cnt_reg + CW'(push.cnt) - CW'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (2'(i) < push.cnt)
            begin
                mem_reg[wr_ptr_reg + AW'(i)] <= push.beat[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("result queue written without room");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_pop_drops: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.cnt == 2'd0 |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("result queue count did not drop on a read");

endmodule

// ===== src/escape_sequence_unescaper.sv =====
// Top level of the escape sequence unescaper: input register, decoder, result queue.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     in_beat  (esu_pkg::in_beat_t: raw byte, last flag)
//   result    res_valid / res_ready   res_beat (esu_pkg::res_beat_t: byte, valid, ends)
//
// One input beat is accepted per cycle while the result queue has room. A beat is
// held in the input register, decoded from there, and its results are written
// into the result queue, where they can be read. Most beats give one result or none;
// a beat that gives two or three results occupies the result port for each of them
// in turn, and the input stalls only when the result queue has fewer than
// three free entries. Reset clears the input valid flag, the decoder and the
// queue pointers at once; there is no clearing pass.
module escape_sequence_unescaper #(
    parameter int FIFO_DEPTH = esu_pkg::FIFO_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  esu_pkg::in_beat_t  in_beat,
    output logic               res_valid,
    input  logic               res_ready,
    output esu_pkg::res_beat_t res_beat
);
    import esu_pkg::*;

    // Input register: holds the beat being decoded this cycle.
    logic     in_vld_reg, in_vld_next;
    in_beat_t in_data_reg;

    // The decoder consumes the held beat whenever the queue can take three results.
    logic  take;
    logic  room;
    push_t push;

    assign take        = in_vld_reg && room;
    assign in_ready    = !in_vld_reg || take;
    assign in_vld_next = (in_valid && in_ready) || (in_vld_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_beat;
        end
    end

    // Decoder: phase state machine plus the trailer and leading ESC tracking.
    esu_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (in_data_reg),
        .push  (push)
    );

    // Result queue: absorbs the occasional extra results from a flush, a trailer or a held M or octal value.
    esu_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_beat  (res_beat)
    );

endmodule
